// ===== hdl/efcs_pkg.sv =====
// shared types and constants of the edge face curl stencil update block
package efcs_pkg;

    localparam int MAX_EXTENT  = 64;
    localparam int GHOST_WIDTH = 1;
    localparam int EXT_MAX     = MAX_EXTENT + 2 * GHOST_WIDTH;
    localparam int PLANE_MAX   = EXT_MAX * EXT_MAX;
    localparam int ROW_AW      = $clog2(EXT_MAX);
    localparam int PLANE_AW    = $clog2(PLANE_MAX);
    localparam int POS_W       = 7;
    localparam int DIFF_W      = 33;
    localparam int PROD_W      = 65;
    localparam int TERM_W      = 37;
    localparam int SUM_W       = 39;
    localparam int RND_SHIFT   = 28;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_X   = 3'd0;
    localparam logic [2:0] REG_COEF_Y   = 3'd1;
    localparam logic [2:0] REG_COEF_Z   = 3'd2;
    localparam logic [2:0] REG_SIZE_X   = 3'd3;
    localparam logic [2:0] REG_SIZE_Y   = 3'd4;
    localparam logic [2:0] REG_SIZE_Z   = 3'd5;
    localparam logic [2:0] REG_GHOST_LO = 3'd6;
    localparam logic [2:0] REG_GHOST_HI = 3'd7;

    typedef struct packed {
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] v_x;
        logic signed [31:0] v_y;
        logic signed [31:0] v_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic               grid_end;
    } out_beat_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec3_t;

    // cell captured at accept, waiting for the store read data
    typedef struct packed {
        vec3_t b;
        vec3_t v;
        vec3_t prev;
        logic  upd_x;
        logic  upd_y;
        logic  upd_z;
        logic  last;
    } stage_a_t;

endpackage

// ===== hdl/edge_face_curl_stencil_update.sv =====
// top level: configuration, grid position, stage A capture and the two submodules
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data  (B and V, Q16.16)
//  m_      | out       | m_valid / m_ready  | m_data  (A saturated, grid_end)
//  cfg_    | in        | cfg_we             | cfg_index, cfg_data
//
// one cell per cycle sustained while the output is not stalled; after the accepting edge a cell
// passes store read, difference, multiply, round-sum-saturate into the output register
// after reset a clearing pass zeroes all 4356 plane entries and the row memory;
// s_ready stays low during it, configuration writes are taken throughout
// a stalled output stalls the stages behind it, bubbles in between are squeezed out
module edge_face_curl_stencil_update (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  efcs_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output efcs_pkg::out_beat_t m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import efcs_pkg::*;

    logic signed [31:0] coef_x_reg, coef_y_reg, coef_z_reg;
    logic [6:0]         size_x_reg, size_y_reg, size_z_reg;
    logic               ghost_lo_reg, ghost_hi_reg;
    logic [POS_W-1:0]   pos_x_reg, pos_y_reg, pos_z_reg;
    vec3_t              prev_reg;
    stage_a_t           sa_reg;
    logic               sa_valid_reg;
    logic               sa_ready;
    logic               clr_busy;
    logic               acc;
    logic [7:0]         ex, ey, ez;
    logic [7:0]         nx, ny, nz;
    logic               wrap_x, wrap_y, wrap_z;
    logic               row_ok, plane_ok;
    logic [13:0]        pidx;
    vec3_t              v_in, ly, lz;

    function automatic logic [7:0] clamp(input logic [6:0] s);
        if (s == 7'd0) return 8'd1;
        if (s > 7'(MAX_EXTENT)) return 8'(MAX_EXTENT);
        return {1'b0, s};
    endfunction

    function automatic logic in_rng(input logic [POS_W-1:0] idx, input logic [7:0] sz,
                                    input logic glo, input logic ghi);
        logic [8:0] lo, hi;
        lo = 9'd1 + 9'(glo);
        hi = 9'(sz) + 9'd1 + 9'(ghi);
        return (9'(idx) >= lo) && (9'(idx) < hi);
    endfunction

    assign acc     = s_valid && s_ready;
    assign s_ready = sa_ready && !clr_busy;

    // extents and position step
    always_comb begin
        ex       = clamp(size_x_reg) + 8'd2;
        ey       = clamp(size_y_reg) + 8'd2;
        ez       = clamp(size_z_reg) + 8'd2;
        nx       = 8'(pos_x_reg) + 8'd1;
        ny       = 8'(pos_y_reg) + 8'd1;
        nz       = 8'(pos_z_reg) + 8'd1;
        wrap_x   = nx >= ex;
        wrap_y   = ny >= ey;
        wrap_z   = nz >= ez;
        row_ok   = 8'(pos_x_reg) < ex;
        plane_ok = row_ok && (8'(pos_y_reg) < ey);
        pidx     = 14'(pos_y_reg) * 14'(ex) + 14'(pos_x_reg);
        v_in.x   = s_data.v_x;
        v_in.y   = s_data.v_y;
        v_in.z   = s_data.v_z;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_x_reg   <= '0;
            coef_y_reg   <= '0;
            coef_z_reg   <= '0;
            size_x_reg   <= 7'd1;
            size_y_reg   <= 7'd1;
            size_z_reg   <= 7'd1;
            ghost_lo_reg <= 1'b0;
            ghost_hi_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COEF_X:   coef_x_reg   <= cfg_data;
                REG_COEF_Y:   coef_y_reg   <= cfg_data;
                REG_COEF_Z:   coef_z_reg   <= cfg_data;
                REG_SIZE_X:   size_x_reg   <= cfg_data[6:0];
                REG_SIZE_Y:   size_y_reg   <= cfg_data[6:0];
                REG_SIZE_Z:   size_z_reg   <= cfg_data[6:0];
                REG_GHOST_LO: ghost_lo_reg <= cfg_data[0];
                REG_GHOST_HI: ghost_hi_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // grid position, previous cell and stage A valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            prev_reg     <= '0;
            sa_valid_reg <= 1'b0;
        end else begin
            if (sa_ready) begin
                sa_valid_reg <= acc;
            end
            if (acc) begin
                prev_reg <= v_in;
                if (wrap_x) begin
                    pos_x_reg <= '0;
                    if (wrap_y) begin
                        pos_y_reg <= '0;
                        pos_z_reg <= wrap_z ? '0 : nz[POS_W-1:0];
                    end else begin
                        pos_y_reg <= ny[POS_W-1:0];
                    end
                end else begin
                    pos_x_reg <= nx[POS_W-1:0];
                end
            end
        end
    end

    // stage A payload
    always_ff @(posedge aclk) begin
        if (acc) begin
            sa_reg.b.x   <= s_data.b_x;
            sa_reg.b.y   <= s_data.b_y;
            sa_reg.b.z   <= s_data.b_z;
            sa_reg.v     <= v_in;
            sa_reg.prev  <= prev_reg;
            sa_reg.upd_x <= in_rng(pos_x_reg, clamp(size_x_reg), ghost_lo_reg, ghost_hi_reg);
            sa_reg.upd_y <= in_rng(pos_y_reg, clamp(size_y_reg), ghost_lo_reg, ghost_hi_reg);
            sa_reg.upd_z <= in_rng(pos_z_reg, clamp(size_z_reg), ghost_lo_reg, ghost_hi_reg);
            sa_reg.last  <= wrap_x && wrap_y && wrap_z;
        end
    end

    efcs_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .acc        (acc),
        .row_ok     (row_ok),
        .row_addr   (pos_x_reg[ROW_AW-1:0]),
        .plane_ok   (plane_ok),
        .plane_addr (pidx[PLANE_AW-1:0]),
        .v          (v_in),
        .ly         (ly),
        .lz         (lz),
        .clr_busy   (clr_busy)
    );

    efcs_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sa_valid (sa_valid_reg),
        .sa       (sa_reg),
        .ly       (ly),
        .lz       (lz),
        .coef_x   (coef_x_reg),
        .coef_y   (coef_y_reg),
        .coef_z   (coef_z_reg),
        .sa_ready (sa_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef SYNTHESIS
    // no cell taken while the memories are being cleared
    a_no_acc_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready) else $error("beat accepted during clearing pass");

    // clearing pass runs once
    a_clr_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_busy |=> !clr_busy) else $error("clearing pass restarted");

    // last cell of the grid returns the position to the origin
    a_last_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && wrap_x && wrap_y && wrap_z) |=>
        (pos_x_reg == '0 && pos_y_reg == '0 && pos_z_reg == '0))
        else $error("position not reset after last cell");

    // stage A holds while the difference stage is blocked
    a_sa_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (sa_valid_reg && !sa_ready) |=> (sa_valid_reg && $stable(sa_reg)))
        else $error("stage A lost under stall");
`endif

endmodule

// ===== hdl/efcs_store.sv =====
// row and plane memories of V with the clearing pass after reset
module efcs_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          acc,
    input  logic                          row_ok,
    input  logic [efcs_pkg::ROW_AW-1:0]   row_addr,
    input  logic                          plane_ok,
    input  logic [efcs_pkg::PLANE_AW-1:0] plane_addr,
    input  efcs_pkg::vec3_t               v,
    output efcs_pkg::vec3_t               ly,
    output efcs_pkg::vec3_t               lz,
    output logic                          clr_busy
);
    import efcs_pkg::*;

    vec3_t row_mem [EXT_MAX];
    vec3_t plane_mem [PLANE_MAX];

    vec3_t                row_rd_reg;
    vec3_t                plane_rd_reg;
    logic                 row_ok_reg;
    logic                 plane_ok_reg;
    logic                 clr_busy_reg;
    logic [PLANE_AW-1:0]  clr_idx_reg;

    // clearing pass over both memories
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_idx_reg == PLANE_AW'(PLANE_MAX - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // writes: clear or the accepted cell's V
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            plane_mem[clr_idx_reg] <= '0;
            if (clr_idx_reg < PLANE_AW'(EXT_MAX)) begin
                row_mem[clr_idx_reg[ROW_AW-1:0]] <= '0;
            end
        end else if (acc) begin
            if (row_ok) begin
                row_mem[row_addr] <= v;
            end
            if (plane_ok) begin
                plane_mem[plane_addr] <= v;
            end
        end
    end

    // reads see the old entry, before this cell's write
    always_ff @(posedge aclk) begin
        if (acc) begin
            row_rd_reg   <= row_mem[row_addr];
            plane_rd_reg <= plane_mem[plane_addr];
            row_ok_reg   <= row_ok;
            plane_ok_reg <= plane_ok;
        end
    end

    assign ly       = row_ok_reg ? row_rd_reg : '0;
    assign lz       = plane_ok_reg ? plane_rd_reg : '0;
    assign clr_busy = clr_busy_reg;

endmodule

// ===== hdl/efcs_datapath.sv =====
// difference, multiply and round-sum-saturate stages with the output register
module efcs_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                sa_valid,
    input  efcs_pkg::stage_a_t  sa,
    input  efcs_pkg::vec3_t     ly,
    input  efcs_pkg::vec3_t     lz,
    input  logic signed [31:0]  coef_x,
    input  logic signed [31:0]  coef_y,
    input  logic signed [31:0]  coef_z,
    output logic                sa_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output efcs_pkg::out_beat_t m_data
);
    import efcs_pkg::*;

    logic                     vb_reg, vc_reg, vd_reg;
    logic                     en_b, en_c, en_d;
    vec3_t                    bb_reg, bc_reg;
    logic                     lb_reg, lc_reg;
    logic signed [DIFF_W-1:0] d_reg [6];
    logic signed [PROD_W-1:0] p_reg [6];
    logic signed [DIFF_W-1:0] d_next [6];
    logic signed [TERM_W-1:0] t [6];
    logic signed [SUM_W-1:0]  s_x, s_y, s_z;
    out_beat_t                out_reg;
    out_beat_t                out_next;

    // stage enables, a bubble lets upstream move
    assign en_d     = !vd_reg || m_ready;
    assign en_c     = !vc_reg || en_d;
    assign en_b     = !vb_reg || en_c;
    assign sa_ready = !sa_valid || en_b;

    function automatic logic signed [DIFF_W-1:0] dif(
        input logic signed [31:0] a, input logic signed [31:0] b, input logic en);
        logic signed [DIFF_W-1:0] r;
        r = DIFF_W'(a) - DIFF_W'(b);
        return en ? r : '0;
    endfunction

    // neighbor differences, sign of the curl folded into the order
    always_comb begin
        d_next[0] = dif(sa.prev.z, sa.v.z, sa.upd_x);
        d_next[1] = dif(sa.v.y, sa.prev.y, sa.upd_x);
        d_next[2] = dif(sa.v.z, ly.z, sa.upd_y);
        d_next[3] = dif(ly.x, sa.v.x, sa.upd_y);
        d_next[4] = dif(lz.y, sa.v.y, sa.upd_z);
        d_next[5] = dif(sa.v.x, lz.x, sa.upd_z);
    end

    // round each product, add to B and saturate
    function automatic logic signed [TERM_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = (p + (PROD_W'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        return q[TERM_W-1:0];
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [SUM_W-1:0] s);
        if (s > SUM_W'(32'sh7fffffff)) begin
            return 32'sh7fffffff;
        end else if (s < SUM_W'(-33'sh80000000)) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            t[i] = rnd(p_reg[i]);
        end
        s_x = SUM_W'(bc_reg.x) + SUM_W'(t[2]) + SUM_W'(t[4]);
        s_y = SUM_W'(bc_reg.y) + SUM_W'(t[0]) + SUM_W'(t[5]);
        s_z = SUM_W'(bc_reg.z) + SUM_W'(t[1]) + SUM_W'(t[3]);
        out_next.a_x      = sat(s_x);
        out_next.a_y      = sat(s_y);
        out_next.a_z      = sat(s_z);
        out_next.grid_end = lc_reg;
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (en_b) vb_reg <= sa_valid;
            if (en_c) vc_reg <= vb_reg;
            if (en_d) vd_reg <= vc_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (en_b) begin
            bb_reg <= sa.b;
            lb_reg <= sa.last;
            for (int i = 0; i < 6; i++) begin
                d_reg[i] <= d_next[i];
            end
        end
        if (en_c) begin
            bc_reg   <= bb_reg;
            lc_reg   <= lb_reg;
            p_reg[0] <= PROD_W'(coef_x) * PROD_W'(d_reg[0]);
            p_reg[1] <= PROD_W'(coef_x) * PROD_W'(d_reg[1]);
            p_reg[2] <= PROD_W'(coef_y) * PROD_W'(d_reg[2]);
            p_reg[3] <= PROD_W'(coef_y) * PROD_W'(d_reg[3]);
            p_reg[4] <= PROD_W'(coef_z) * PROD_W'(d_reg[4]);
            p_reg[5] <= PROD_W'(coef_z) * PROD_W'(d_reg[5]);
        end
        if (en_d) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vd_reg;
    assign m_data  = out_reg;

endmodule

// ===== dv/edge_face_curl_stencil_update_tb.sv =====
// testbench of the edge face curl stencil update block: curl update predictor and scoreboard
module edge_face_curl_stencil_update_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import efcs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ROW_N = 66;
    localparam int PLANE_N = 66 * 66;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    edge_face_curl_stencil_update u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state and configuration
    logic signed [63:0] cx, cy, cz;
    int unsigned sz_x, sz_y, sz_z, g_lo, g_hi;
    logic signed [63:0] prev_v [3];
    logic signed [63:0] row_v [ROW_N][3];
    logic signed [63:0] plane_v [PLANE_N][3];
    int unsigned px, py, pz;

    out_beat_t a_expected [$];
    bit failed = 1'b0;
    int unsigned cycle_count = 0;
    bit idle_on = 1'b1;
    bit hold_sink = 1'b0;

    function automatic int unsigned clamp_extent(int unsigned s);
        if (s < 1) return 1;
        if (s > MAX_EXTENT) return MAX_EXTENT;
        return s;
    endfunction

    function automatic bit updates(int unsigned idx, int unsigned s);
        return idx >= 1 + g_lo && idx < s + 1 + g_hi;
    endfunction

    // round half up of p / 2^28, floor division
    function automatic logic signed [63:0] curl_term(logic signed [63:0] c,
            logic signed [63:0] cur, logic signed [63:0] left, bit neg);
        logic signed [63:0] p;
        p = c * (cur - left);
        if (neg) p = -p;
        return (p + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic out_beat_t predict_curl(in_beat_t c);
        int unsigned sx, sy, sz, ex, ey, ez, pidx;
        bit row_ok, plane_ok;
        logic signed [63:0] b [3], v [3], ly [3], lz [3];
        logic signed [63:0] ax, ay, az;
        out_beat_t r;
        sx = clamp_extent(sz_x); sy = clamp_extent(sz_y); sz = clamp_extent(sz_z);
        ex = sx + 2; ey = sy + 2; ez = sz + 2;
        row_ok = px < ex;
        plane_ok = row_ok && py < ey;
        pidx = py * ex + px;
        b[0] = 64'(c.b_x); b[1] = 64'(c.b_y); b[2] = 64'(c.b_z);
        v[0] = 64'(c.v_x); v[1] = 64'(c.v_y); v[2] = 64'(c.v_z);
        for (int k = 0; k < 3; k++) begin
            ly[k] = row_ok ? row_v[px][k] : 64'sd0;
            lz[k] = plane_ok ? plane_v[pidx][k] : 64'sd0;
        end
        ax = b[0]; ay = b[1]; az = b[2];
        if (updates(px, sx)) begin
            ay += curl_term(cx, v[2], prev_v[2], 1);
            az += curl_term(cx, v[1], prev_v[1], 0);
        end
        if (updates(py, sy)) begin
            ax += curl_term(cy, v[2], ly[2], 0);
            az += curl_term(cy, v[0], ly[0], 1);
        end
        if (updates(pz, sz)) begin
            ax += curl_term(cz, v[1], lz[1], 1);
            ay += curl_term(cz, v[0], lz[0], 0);
        end
        for (int k = 0; k < 3; k++) begin
            prev_v[k] = v[k];
            if (row_ok) row_v[px][k] = v[k];
            if (plane_ok) plane_v[pidx][k] = v[k];
        end
        r.grid_end = (px + 1 >= ex) && (py + 1 >= ey) && (pz + 1 >= ez);
        if (px + 1 >= ex) begin
            px = 0;
            if (py + 1 >= ey) begin
                py = 0;
                pz = (pz + 1 >= ez) ? 0 : pz + 1;
            end else begin
                py++;
            end
        end else begin
            px++;
        end
        r.a_x = sat32(ax); r.a_y = sat32(ay); r.a_z = sat32(az);
        return r;
    endfunction

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls and result checks
    always @(posedge aclk) begin
        out_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (a_expected.size() == 0) begin
                $display("%0t unexpected beat %h", $time, m_data);
                failed = 1'b1;
            end else begin
                exp_beat = a_expected.pop_front();
                if (m_data.a_x !== exp_beat.a_x) begin
                    $display("%0t a_x exp %h got %h", $time, exp_beat.a_x, m_data.a_x);
                    failed = 1'b1;
                end
                if (m_data.a_y !== exp_beat.a_y) begin
                    $display("%0t a_y exp %h got %h", $time, exp_beat.a_y, m_data.a_y);
                    failed = 1'b1;
                end
                if (m_data.a_z !== exp_beat.a_z) begin
                    $display("%0t a_z exp %h got %h", $time, exp_beat.a_z, m_data.a_z);
                    failed = 1'b1;
                end
                if (m_data.grid_end !== exp_beat.grid_end) begin
                    $display("%0t grid_end exp %b got %b", $time, exp_beat.grid_end,
                             m_data.grid_end);
                    failed = 1'b1;
                end
            end
        end
        m_ready <= !hold_sink && (!idle_on || $urandom_range(99) >= 27);
    end

    // configuration write, block idle; the caller drops the write enable
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        case (idx)
            REG_COEF_X:   cx = 64'($signed(val));
            REG_COEF_Y:   cy = 64'($signed(val));
            REG_COEF_Z:   cz = 64'($signed(val));
            REG_SIZE_X:   sz_x = 32'(val[6:0]);
            REG_SIZE_Y:   sz_y = 32'(val[6:0]);
            REG_SIZE_Z:   sz_z = 32'(val[6:0]);
            REG_GHOST_LO: g_lo = 32'(val[0]);
            REG_GHOST_HI: g_hi = 32'(val[0]);
            default: ;
        endcase
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (a_expected.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_grid(logic [31:0] x, logic [31:0] y, logic [31:0] z,
            logic [6:0] nx, logic [6:0] ny, logic [6:0] nz, bit lo, bit hi);
        drain();
        write_reg(REG_COEF_X, x); write_reg(REG_COEF_Y, y); write_reg(REG_COEF_Z, z);
        write_reg(REG_SIZE_X, 32'(nx)); write_reg(REG_SIZE_Y, 32'(ny));
        write_reg(REG_SIZE_Z, 32'(nz));
        write_reg(REG_GHOST_LO, 32'(lo)); write_reg(REG_GHOST_HI, 32'(hi));
        cfg_we <= 1'b0;
    endtask

    // send one cell beat
    task automatic send_cell(in_beat_t c);
        while (idle_on && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        a_expected.push_back(predict_curl(c));
    endtask

    function automatic logic [31:0] rand_word;
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(8191) - 4096;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_beat_t rand_cell;
        in_beat_t c;
        c.b_x = rand_word(); c.b_y = rand_word(); c.b_z = rand_word();
        c.v_x = rand_word(); c.v_y = rand_word(); c.v_z = rand_word();
        return c;
    endfunction

    task automatic test_extremes;
        in_beat_t c;
        set_grid(32'h7fffffff, 32'h80000000, 32'h10000000, 7'd2, 7'd1, 7'd1, 1'b0, 1'b0);
        for (int i = 0; i < 12; i++) begin
            c = '{default: (i[0] ? 32'h7fffffff : 32'h80000000)};
            if (i > 5) c = rand_cell();
            send_cell(c);
        end
    endtask

    task automatic test_ghost_flags;
        set_grid(32'h08000000, 32'hf8000000, 32'h10000000, 7'd1, 7'd2, 7'd1, 1'b1, 1'b1);
        for (int i = 0; i < 36; i++) send_cell(rand_cell());
    endtask

    // size outside range and change in mid grid
    task automatic test_size_limits;
        set_grid(32'h10000000, 32'h10000000, 32'h10000000, 7'd0, 7'd0, 7'd0, 1'b0, 1'b1);
        for (int i = 0; i < 10; i++) send_cell(rand_cell());
        set_grid(32'h10000000, 32'h01000000, 32'h00100000, 7'd3, 7'd1, 7'd1, 1'b0, 1'b0);
        for (int i = 0; i < 7; i++) send_cell(rand_cell());
        set_grid(32'h10000000, 32'h01000000, 32'h00100000, 7'd1, 7'd1, 7'd1, 1'b1, 1'b0);
        for (int i = 0; i < 30; i++) send_cell(rand_cell());
        set_grid(32'h00000001, 32'h00000000, 32'hffffffff, 7'd127, 7'd1, 7'd1, 1'b0, 1'b0);
        for (int i = 0; i < 140; i++) send_cell(rand_cell());
    endtask

    task automatic test_random_grids;
        int n;
        for (int g = 0; g < 13; g++) begin
            set_grid(rand_word(), rand_word(), rand_word(), 7'($urandom_range(1, 5)),
                     7'($urandom_range(1, 4)), 7'($urandom_range(1, 3)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
            n = (clamp_extent(sz_x) + 2) * (clamp_extent(sz_y) + 2) * (clamp_extent(sz_z) + 2);
            if ($urandom_range(3) == 0) n = n + $urandom_range(n);
            idle_on = (g != 5);
            for (int i = 0; i < n && i < 200; i++) send_cell(rand_cell());
        end
        idle_on = 1'b1;
    endtask

    // receiver held off while the sender keeps offering
    task automatic test_backpressure;
        set_grid(32'h10000000, 32'h10000000, 32'h10000000, 7'd3, 7'd3, 7'd3, 1'b0, 1'b0);
        fork
            begin
                hold_sink = 1'b1;
                repeat (60) @(posedge aclk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 200; i++) send_cell(rand_cell());
        join
    endtask

    initial begin
        cx = 0; cy = 0; cz = 0; sz_x = 1; sz_y = 1; sz_z = 1; g_lo = 0; g_hi = 0;
        px = 0; py = 0; pz = 0;
        for (int k = 0; k < 3; k++) prev_v[k] = 0;
        for (int i = 0; i < ROW_N; i++) for (int k = 0; k < 3; k++) row_v[i][k] = 0;
        for (int i = 0; i < PLANE_N; i++) for (int k = 0; k < 3; k++) plane_v[i][k] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_ghost_flags();
        test_size_limits();
        test_random_grids();
        test_backpressure();
        drain();
        repeat (20) @(posedge aclk);
        if (!failed && a_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/efcs_pkg.sv
hdl/efcs_store.sv
hdl/efcs_datapath.sv
hdl/edge_face_curl_stencil_update.sv
dv/edge_face_curl_stencil_update_tb.sv
